// ===== design/sv39pw_pkg.sv =====
// Shared types and constants for the Sv39 read-probe page walker.
`default_nettype none
package sv39pw_pkg;

    localparam int unsigned LEVELS      = 3;
    localparam int unsigned LVL_W       = 2;
    localparam int unsigned IDX_BITS    = 9;
    localparam int unsigned HELD_W      = LEVELS * IDX_BITS;
    localparam int unsigned PAGE_W      = 54;
    localparam int unsigned ROOT_W      = 44;
    localparam int unsigned XLEN        = 64;
    localparam int unsigned PAGE_SHIFT  = 12;
    localparam int unsigned CANON_SHIFT = 38;
    localparam int unsigned PPN_SHIFT   = 10;
    localparam int unsigned CFG_IDX_W   = 1;

    localparam logic [LVL_W-1:0] LAST_LEVEL = LVL_W'(LEVELS - 1);

    localparam int unsigned PTE_V = 0;
    localparam int unsigned PTE_R = 1;
    localparam int unsigned PTE_W = 2;
    localparam int unsigned PTE_X = 3;

    localparam logic CMD_PROBE = 1'b0;
    localparam logic CMD_RESP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 1'b1;

    typedef struct packed {
        logic [ROOT_W-1:0] root_page;
        logic [XLEN-1:0]   map_offset;
    } t_cfg;

    typedef struct packed {
        logic            has_result;
        logic            is_request;
        logic [XLEN-1:0] read_address;
        logic            readable;
    } t_walk_res;

endpackage
`default_nettype wire

// ===== design/sv39_page_walk_read_probe_top.sv =====
// Top level of the Sv39 read-probe page walker with input and result registers.
// Each item is captured in the input register; the walk step (canonical check, entry
// decode, one three-term address add) runs on it once the result register is free, and
// the result lands in the result register, so one item per clock is sustained while the
// result side keeps up. A result is presented once it has passed the input and result
// registers and can transfer at the next clock edge at the earliest. A probe (tuser = 0)
// either yields an immediate not-readable answer or a read request for the root entry; a
// memory response (tuser = 1) yields the next request or the final answer, and is dropped
// without a result when no walk is in progress. A new probe during a walk restarts it.
// Configuration writes are taken at any time but are meant to be issued while the block is
// idle.
`default_nettype none
module sv39_page_walk_read_probe_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [127:0]                     i_s_axis_tdata,  // virtual_address, table_entry
    input  wire logic                             i_s_axis_tuser,  // cmd
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    output logic [71:0]                           o_m_axis_tdata,  // read_address, readable, pad
    output logic                                  o_m_axis_tuser,  // is_request
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [sv39pw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [sv39pw_pkg::XLEN-1:0]      i_cfg_data
);
    import sv39pw_pkg::*;

    t_cfg      cfg;
    t_walk_res res;

    logic            r_in_valid;
    logic            r_in_cmd;
    logic [XLEN-1:0] r_in_va;
    logic [XLEN-1:0] r_in_pte;

    logic            r_out_valid;
    logic            r_out_req;
    logic [XLEN-1:0] r_out_addr;
    logic            r_out_rd;

    logic out_free;
    logic advance;
    logic in_xfer;

    assign o_cfg_ready = 1'b1;

    sv39pw_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign advance         = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_cmd <= i_s_axis_tuser;
            r_in_va  <= i_s_axis_tdata[XLEN-1:0];
            r_in_pte <= i_s_axis_tdata[2*XLEN-1:XLEN];
        end
    end

    sv39pw_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_cmd   (r_in_cmd),
        .i_va    (r_in_va),
        .i_pte   (r_in_pte),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && res.has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.has_result) begin
            r_out_req  <= res.is_request;
            r_out_addr <= res.read_address;
            r_out_rd   <= res.readable;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_req;
    assign o_m_axis_tdata  = {7'b0, r_out_rd, r_out_addr};

endmodule
`default_nettype wire

// ===== design/sv39pw_cfg.sv =====
// Configuration registers: root table page number and direct-map offset.
`default_nettype none
module sv39pw_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_wr_en,
    input  wire logic [sv39pw_pkg::CFG_IDX_W-1:0] i_wr_index,
    input  wire logic [sv39pw_pkg::XLEN-1:0]      i_wr_data,
    output sv39pw_pkg::t_cfg                      o_cfg
);
    import sv39pw_pkg::*;

    logic [ROOT_W-1:0] r_root;
    logic [XLEN-1:0]   r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root   <= '0;
            r_offset <= '0;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_ROOT:   r_root   <= i_wr_data[ROOT_W-1:0];
                CFG_OFFSET: r_offset <= i_wr_data;
                default:    ;
            endcase
        end
    end

    assign o_cfg.root_page  = r_root;
    assign o_cfg.map_offset = r_offset;

endmodule
`default_nettype wire

// ===== design/sv39pw_walk.sv =====
// Walk state and single-step decision logic for one probe or table entry.
`default_nettype none
module sv39pw_walk (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_fire,
    input  wire logic                        i_cmd,
    input  wire logic [sv39pw_pkg::XLEN-1:0] i_va,
    input  wire logic [sv39pw_pkg::XLEN-1:0] i_pte,
    input  wire sv39pw_pkg::t_cfg            i_cfg,
    output sv39pw_pkg::t_walk_res            o_res
);
    import sv39pw_pkg::*;

    logic              r_active;
    logic [LVL_W-1:0]  r_level;
    logic [HELD_W-1:0] r_held;
    logic [PAGE_W-1:0] r_page;

    logic              n_active;
    logic [LVL_W-1:0]  n_level;
    logic [HELD_W-1:0] n_held;
    logic [PAGE_W-1:0] n_page;

    logic                canonical;
    logic                request;
    logic                final_ans;
    logic                readable;
    logic [IDX_BITS-1:0] idx;
    logic [XLEN-1:0]     addr;

    assign canonical = (&i_va[XLEN-1:CANON_SHIFT]) || !(|i_va[XLEN-1:CANON_SHIFT]);

    always_comb begin
        n_active  = r_active;
        n_level   = r_level;
        n_held    = r_held;
        n_page    = r_page;
        request   = 1'b0;
        final_ans = 1'b0;
        readable  = 1'b0;
        if (i_cmd == CMD_PROBE) begin
            if (!canonical || i_cfg.map_offset == '0) begin
                final_ans = 1'b1;
                n_active  = 1'b0;
            end else begin
                request  = 1'b1;
                n_active = 1'b1;
                n_level  = '0;
                n_held   = i_va[PAGE_SHIFT+HELD_W-1:PAGE_SHIFT];
                n_page   = PAGE_W'(i_cfg.root_page);
            end
        end else if (r_active) begin
            if (!i_pte[PTE_V]) begin
                final_ans = 1'b1;
                n_active  = 1'b0;
            end else if (i_pte[PTE_R] || i_pte[PTE_W] || i_pte[PTE_X]) begin
                final_ans = 1'b1;
                readable  = i_pte[PTE_R];
                n_active  = 1'b0;
            end else if (r_level >= LAST_LEVEL) begin
                final_ans = 1'b1;
                n_active  = 1'b0;
            end else begin
                request = 1'b1;
                n_level = r_level + LVL_W'(1);
                n_page  = i_pte[PPN_SHIFT+PAGE_W-1:PPN_SHIFT];
            end
        end
    end

    always_comb begin
        case (n_level)
            2'd0:    idx = n_held[3*IDX_BITS-1:2*IDX_BITS];
            2'd1:    idx = n_held[2*IDX_BITS-1:IDX_BITS];
            2'd2:    idx = n_held[IDX_BITS-1:0];
            default: idx = n_held[3*IDX_BITS-1:2*IDX_BITS];
        endcase
    end

    assign addr = {n_page[XLEN-PAGE_SHIFT-1:0], {PAGE_SHIFT{1'b0}}}
                + i_cfg.map_offset
                + {{(XLEN-IDX_BITS-3){1'b0}}, idx, 3'b000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_level  <= '0;
            r_held   <= '0;
            r_page   <= '0;
        end else if (i_fire) begin
            r_active <= n_active;
            r_level  <= n_level;
            r_held   <= n_held;
            r_page   <= n_page;
        end
    end

    assign o_res.has_result   = request || final_ans;
    assign o_res.is_request   = request;
    assign o_res.read_address = request ? addr : '0;
    assign o_res.readable     = readable;

endmodule
`default_nettype wire

// ===== design/sv39pw_chk.sv =====
// Port-level checker for the Sv39 read-probe page walker, bound to the top level.
`default_nettype none
module sv39pw_chk (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [71:0]  o_m_axis_tdata,
    input wire logic         o_m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    a_answer_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata[63:0] == 64'd0)
        else $error("final answer carries an address");

    a_request_not_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> !o_m_axis_tdata[64])
        else $error("read request marked readable");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind sv39_page_walk_read_probe_top sv39pw_chk u_chk (.*);
`default_nettype wire
